@@ rtl/wbsc_pkg.sv @@
package wbsc_pkg;

  // Geometry
  localparam int SETS        = 64;
  localparam int SLOTS       = 2 * SETS;
  localparam int SET_W       = $clog2(SETS);
  localparam int SECTOR_BITS = 24;
  localparam int SLOT_W      = 7;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WBACK = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WBACK,
    ST_FILL,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  capture;
    logic  lookup;
    logic  emit;
    kind_t kind;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_wb;
    logic need_fill;
    logic fill_pending;
  } dp_status_t;

  // Per-set replacement and dirty bits, kept in RAM
  typedef struct packed {
    logic victim_way0;
    logic dirty1;
    logic dirty0;
  } set_meta_t;

endpackage

@@ rtl/wbsc_ram.sv @@
module wbsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/wbsc_datapath.sv @@
module wbsc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  wbsc_pkg::ctrl_cmd_t             cmd,
  output wbsc_pkg::dp_status_t            status,
  input  logic [wbsc_pkg::MODE_W-1:0]     mode,
  input  logic [wbsc_pkg::SECTOR_BITS-1:0] sector,
  input  logic [wbsc_pkg::SLOT_W-1:0]     flush_slot,
  output logic                            strobe,
  output logic [wbsc_pkg::KIND_W-1:0]     kind,
  output logic [wbsc_pkg::SECTOR_BITS-1:0] disk_sector,
  output logic [wbsc_pkg::SLOT_W-1:0]     slot,
  output logic                            hit,
  output logic                            last
);
  import wbsc_pkg::*;

  // Captured request
  mode_t                  req_mode;
  logic [SECTOR_BITS-1:0] req_sector;
  logic [SLOT_W-1:0]      req_fslot;

  // Per-slot valid bits
  logic [SETS-1:0] valid0, valid1;

  // Tag and set state RAM ports
  logic [SET_W-1:0]       rd_set;
  logic [SECTOR_BITS-1:0] tag0, tag1;
  logic                   we0, we1;
  set_meta_t              meta_rd, meta_next;

  // Lookup outcome
  logic [SET_W-1:0]       set_idx;
  logic                   v0, v1, d0, d1, h0, h1, vic0;
  logic                   fl_in_range, fl_way;
  logic                   lk_way, lk_hit, lk_wb, lk_fill, lk_done_hit;
  logic [SECTOR_BITS-1:0] lk_wb_tag, lk_done_sector;
  logic [SLOT_W-1:0]      lk_slot;

  // Held results
  logic [SLOT_W-1:0]      slot_q;
  logic [SECTOR_BITS-1:0] wb_tag_q, done_sector_q;
  logic                   done_hit_q, fill_pending;

  // Read address comes straight from the request ports on accept
  assign rd_set = (mode_t'(mode) == MODE_FLUSH) ? flush_slot[SET_W-1:0]
                                                : sector[SET_W-1:0];

  wbsc_ram #(.WIDTH(SECTOR_BITS), .DEPTH(SETS)) u_tag0 (
    .clk   (clk),
    .we    (we0),
    .waddr (set_idx),
    .wdata (req_sector),
    .re    (cmd.capture),
    .raddr (rd_set),
    .rdata (tag0)
  );

  wbsc_ram #(.WIDTH(SECTOR_BITS), .DEPTH(SETS)) u_tag1 (
    .clk   (clk),
    .we    (we1),
    .waddr (set_idx),
    .wdata (req_sector),
    .re    (cmd.capture),
    .raddr (rd_set),
    .rdata (tag1)
  );

  // Dirty and replacement bits: read on accept, written back in lookup
  wbsc_ram #(.WIDTH($bits(set_meta_t)), .DEPTH(SETS)) u_meta (
    .clk   (clk),
    .we    (cmd.lookup),
    .waddr (set_idx),
    .wdata (meta_next),
    .re    (cmd.capture),
    .raddr (rd_set),
    .rdata (meta_rd)
  );

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode   <= mode_t'(mode);
      req_sector <= sector;
      req_fslot  <= flush_slot;
    end
  end

  // Tag compare and victim choice
  assign set_idx     = (req_mode == MODE_FLUSH) ? req_fslot[SET_W-1:0]
                                                : req_sector[SET_W-1:0];
  assign v0          = valid0[set_idx];
  assign v1          = valid1[set_idx];
  // dirty bits only count for valid slots
  assign d0          = meta_rd.dirty0;
  assign d1          = meta_rd.dirty1;
  // a set never accessed since reset has no valid way and evicts way 0
  assign vic0        = (v0 || v1) ? meta_rd.victim_way0 : 1'b1;
  assign h0          = v0 && (tag0 == req_sector);
  assign h1          = v1 && (tag1 == req_sector);
  assign fl_in_range = 32'(req_fslot) < 32'(SLOTS);
  assign fl_way      = 32'(req_fslot) >= 32'(SETS);

  always_comb begin
    lk_way         = 1'b0;
    lk_hit         = 1'b0;
    lk_wb          = 1'b0;
    lk_fill        = 1'b0;
    lk_done_hit    = 1'b0;
    lk_wb_tag      = tag0;
    lk_done_sector = req_sector;
    lk_slot        = '0;
    case (req_mode)
      MODE_READ, MODE_WRITE: begin
        if (h0 || h1) begin
          lk_way = !h0;
          lk_hit = 1'b1;
        end else begin
          lk_way  = !vic0;
          lk_wb   = lk_way ? (v1 && d1) : (v0 && d0);
          lk_fill = (req_mode == MODE_READ);
        end
        lk_wb_tag   = lk_way ? tag1 : tag0;
        lk_done_hit = lk_hit;
        lk_slot     = SLOT_W'({lk_way, set_idx});
      end
      MODE_FLUSH: begin
        lk_slot        = req_fslot;
        lk_done_sector = '0;
        if (fl_in_range) begin
          lk_way         = fl_way;
          lk_wb          = fl_way ? (v1 && d1) : (v0 && d0);
          lk_wb_tag      = fl_way ? tag1 : tag0;
          lk_done_hit    = fl_way ? v1 : v0;
          lk_done_sector = lk_done_hit ? lk_wb_tag : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Tag writes on a read or write miss
  assign we0 = cmd.lookup && (req_mode == MODE_READ || req_mode == MODE_WRITE)
               && !lk_hit && !lk_way;
  assign we1 = cmd.lookup && (req_mode == MODE_READ || req_mode == MODE_WRITE)
               && !lk_hit && lk_way;

  // Next dirty and replacement bits of the looked-up set
  always_comb begin
    meta_next             = meta_rd;
    meta_next.victim_way0 = vic0;
    case (req_mode)
      MODE_READ, MODE_WRITE: begin
        if (lk_hit) begin
          if (req_mode == MODE_WRITE) begin
            if (lk_way) meta_next.dirty1 = 1'b1;
            else        meta_next.dirty0 = 1'b1;
          end
        end else if (lk_way) begin
          meta_next.dirty1 = (req_mode == MODE_WRITE);
        end else begin
          meta_next.dirty0 = (req_mode == MODE_WRITE);
        end
        // way 1 just used means way 0 goes next
        meta_next.victim_way0 = lk_way;
      end
      MODE_FLUSH: begin
        if (fl_in_range && lk_wb) begin
          if (lk_way) meta_next.dirty1 = 1'b0;
          else        meta_next.dirty0 = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= '0;
      valid1 <= '0;
    end else begin
      if (we0) valid0[set_idx] <= 1'b1;
      if (we1) valid1[set_idx] <= 1'b1;
    end
  end

  // Hold lookup results for the emit states
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      slot_q        <= lk_slot;
      wb_tag_q      <= lk_wb_tag;
      done_sector_q <= lk_done_sector;
      done_hit_q    <= lk_done_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_pending <= 1'b0;
    end else if (cmd.lookup) begin
      fill_pending <= lk_fill;
    end
  end

  assign status.need_wb      = lk_wb;
  assign status.need_fill    = lk_fill;
  assign status.fill_pending = fill_pending;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind <= cmd.kind;
      slot <= slot_q;
      case (cmd.kind)
        KIND_WBACK: begin
          disk_sector <= wb_tag_q;
          hit         <= 1'b0;
          last        <= 1'b0;
        end
        KIND_FILL: begin
          disk_sector <= req_sector;
          hit         <= 1'b0;
          last        <= 1'b0;
        end
        default: begin
          disk_sector <= done_sector_q;
          hit         <= done_hit_q;
          last        <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/wbsc_ctrl.sv @@
module wbsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  wbsc_pkg::dp_status_t status,
  output wbsc_pkg::ctrl_cmd_t  cmd
);
  import wbsc_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.emit    = 1'b0;
    cmd.kind    = KIND_DONE;
    busy        = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (status.need_wb)        state_next = ST_WBACK;
        else if (status.need_fill) state_next = ST_FILL;
        else                       state_next = ST_DONE;
      end
      ST_WBACK: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_WBACK;
        state_next = status.fill_pending ? ST_FILL : ST_DONE;
      end
      ST_FILL: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_FILL;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_DONE;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/two_way_writeback_sector_cache_ctrl.sv @@
// Tag controller for a two-way set-associative write-back sector cache.
// Request channel: mode, sector and flush_slot are taken at a rising edge
// with start high and busy low. busy stays high until the request is done.
// Result channel: each result shows on kind, disk_sector, slot, hit and last
// for exactly one cycle with strobe high. A request yields an optional write
// back of a dirty victim or flushed slot, an optional fill (read miss), then
// a completion with last set. The receiver has no way to hold results off.
// Timing: the tag and set state memories are read on accept, compared and
// updated in the next cycle, then each result takes its own state. The next
// request may be accepted in the cycle its completion appears on the result
// ports. The accept, the lookup and one state per result set this pace.
// Reset (rst, synchronous) clears every valid bit. Dirty bits count only for
// valid slots and a set with no valid way evicts way 0 first, so tag and set
// state memories keep their contents and no clearing pass is needed.
module two_way_writeback_sector_cache_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [wbsc_pkg::MODE_W-1:0]      mode,
  input  logic [wbsc_pkg::SECTOR_BITS-1:0] sector,
  input  logic [wbsc_pkg::SLOT_W-1:0]      flush_slot,
  output logic                             strobe,
  output logic [wbsc_pkg::KIND_W-1:0]      kind,
  output logic [wbsc_pkg::SECTOR_BITS-1:0] disk_sector,
  output logic [wbsc_pkg::SLOT_W-1:0]      slot,
  output logic                             hit,
  output logic                             last
);
  import wbsc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wbsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  wbsc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .mode        (mode),
    .sector      (sector),
    .flush_slot  (flush_slot),
    .strobe      (strobe),
    .kind        (kind),
    .disk_sector (disk_sector),
    .slot        (slot),
    .hit         (hit),
    .last        (last)
  );

endmodule
